@@ hw/rtl/cau_pkg.sv @@
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int WIDE_W     = PROD_W + 2;
    localparam int QBITS      = DATA_WIDTH + 1;
    localparam int ROOT_W     = DATA_WIDTH;
    localparam int STEPS      = QBITS;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_MAG = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_EQ,
        K_MAG,
        K_NONE
    } kind_t;

    typedef struct packed {
        logic [2:0]                   operation;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_re;
        logic signed [DATA_WIDTH-1:0] res_im;
        logic                         is_equal;
        logic                         div_zero;
        logic                         overflow;
    } res_t;

    typedef struct packed {
        kind_t                        kind;
        logic                         is_equal;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } item_t;

    typedef struct packed {
        logic almost_full;
        logic not_empty;
    } q_stat_t;

    localparam logic signed [WIDE_W-1:0] SAT_HI =
        {{(WIDE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_LO = ~SAT_HI;

    // {overflow, saturated value}
    function automatic logic [DATA_WIDTH:0] sat_wide(input logic signed [WIDE_W-1:0] v);
        if (v > SAT_HI)
            return {1'b1, SAT_HI[DATA_WIDTH-1:0]};
        else if (v < SAT_LO)
            return {1'b1, SAT_LO[DATA_WIDTH-1:0]};
        else
            return {1'b0, v[DATA_WIDTH-1:0]};
    endfunction

endpackage

@@ hw/rtl/cau_front.sv @@
module cau_front
    import cau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  req_t    request,
    input  q_stat_t q_stat,
    output logic    busy,
    output logic    push,
    output item_t   item
);

    logic  accept;
    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    // leave room in the queue for the request held here
    assign busy   = q_stat.almost_full;
    assign accept = start & ~busy;

    always_comb
    begin
        item_next.a_re     = request.a_re;
        item_next.a_im     = request.a_im;
        item_next.b_re     = request.b_re;
        item_next.b_im     = request.b_im;
        item_next.is_equal = 1'b0;
        case (request.operation)
            OP_ADD: item_next.kind = K_ADD;
            OP_SUB: item_next.kind = K_SUB;
            OP_MUL: item_next.kind = K_MUL;
            OP_DIV: item_next.kind = K_DIV;
            OP_EQ:
            begin
                item_next.kind     = K_EQ;
                item_next.is_equal = (request.a_re == request.b_re) &&
                                     (request.a_im == request.b_im);
            end
            OP_MAG: item_next.kind = K_MAG;
            default: item_next.kind = K_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign push = valid_reg;
    assign item = item_reg;

endmodule

@@ hw/rtl/cau_queue.sv @@
module cau_queue
    import cau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    output q_stat_t q_stat,
    output logic    head_valid,
    output item_t   head
);

    item_t             mem_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              pop;

    // back end never stalls: drain one entry every cycle while the queue is not empty
    assign pop        = (count_reg != '0);
    assign count_next = count_reg + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

    assign head_valid         = pop;
    assign head               = mem_reg[rd_reg];
    assign q_stat.not_empty   = pop;
    assign q_stat.almost_full = (count_reg >= (QPTR_W+1)'(QDEPTH-1));

endmodule

@@ hw/rtl/cau_back.sv @@
module cau_back
    import cau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  head_valid,
    input  item_t head,
    output logic  done,
    output res_t  result
);

    typedef struct packed {
        kind_t                        kind;
        logic                         eq;
        logic                         dz;
        logic                         ovf;
        logic                         neg_re;
        logic                         neg_im;
        logic                         big_re;
        logic                         big_im;
        logic [DATA_WIDTH-1:0]        fres_re;
        logic [DATA_WIDTH-1:0]        fres_im;
        logic [PROD_W-1:0]            d;
        logic [PROD_W-1:0]            rr_re;
        logic [PROD_W-1:0]            rr_im;
        logic [QBITS-1:0]             nlo_re;
        logic [QBITS-1:0]             nlo_im;
        logic [QBITS-1:0]             q_re;
        logic [QBITS-1:0]             q_im;
        logic [PROD_W-1:0]            sx;
        logic [ROOT_W+1:0]            srem;
        logic [ROOT_W-1:0]            sroot;
    } stage_t;

    // multiply stage
    logic                         v1_reg;
    kind_t                        k1_reg;
    logic                         eq1_reg;
    logic signed [DATA_WIDTH-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [PROD_W-1:0]     m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [DATA_WIDTH-1:0] x4, x5;

    // sum stage
    logic                         v2_reg;
    kind_t                        k2_reg;
    logic                         eq2_reg;
    logic signed [WIDE_W-1:0]     sre2_reg, sim2_reg;
    logic signed [WIDE_W-1:0]     sre2_next, sim2_next;
    logic [PROD_W-1:0]            sq2_reg;

    // setup stage
    logic                         v3_reg;
    kind_t                        k3_reg;
    logic                         eq3_reg;
    logic                         nre3_reg, nim3_reg;
    logic [PROD_W-1:0]            mre3_reg, mim3_reg;
    logic [PROD_W-1:0]            d3_reg;
    logic [DATA_WIDTH:0]          fre3_reg, fim3_reg;
    logic [DATA_WIDTH:0]          fre3_next, fim3_next;

    // digit pipeline
    stage_t                       pipe_reg  [0:STEPS];
    stage_t                       pipe_next [0:STEPS];
    logic                         pv_reg    [0:STEPS];
    stage_t                       ld;
    logic [PROD_W+FRAC_BITS-1:0]  nfull_re, nfull_im;

    logic                         done_reg;
    res_t                         result_reg;
    res_t                         result_next;

    function automatic stage_t div_step(input stage_t s, input logic sq_en);
        stage_t          o;
        logic [PROD_W:0] tr;
        logic [PROD_W:0] ti;
        logic [ROOT_W+3:0] trem;
        logic [ROOT_W+3:0] trial;
        o  = s;
        tr = {s.rr_re, s.nlo_re[QBITS-1]};
        ti = {s.rr_im, s.nlo_im[QBITS-1]};
        o.nlo_re = {s.nlo_re[QBITS-2:0], 1'b0};
        o.nlo_im = {s.nlo_im[QBITS-2:0], 1'b0};
        if (tr >= {1'b0, s.d})
        begin
            o.rr_re = PROD_W'(tr - {1'b0, s.d});
            o.q_re  = {s.q_re[QBITS-2:0], 1'b1};
        end
        else
        begin
            o.rr_re = tr[PROD_W-1:0];
            o.q_re  = {s.q_re[QBITS-2:0], 1'b0};
        end
        if (ti >= {1'b0, s.d})
        begin
            o.rr_im = PROD_W'(ti - {1'b0, s.d});
            o.q_im  = {s.q_im[QBITS-2:0], 1'b1};
        end
        else
        begin
            o.rr_im = ti[PROD_W-1:0];
            o.q_im  = {s.q_im[QBITS-2:0], 1'b0};
        end
        if (sq_en)
        begin
            trem  = {s.srem, s.sx[PROD_W-1 -: 2]};
            trial = {2'b00, s.sroot, 2'b01};
            if (trem >= trial)
            begin
                o.srem  = (ROOT_W+2)'(trem - trial);
                o.sroot = {s.sroot[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                o.srem  = trem[ROOT_W+1:0];
                o.sroot = {s.sroot[ROOT_W-2:0], 1'b0};
            end
            o.sx = {s.sx[PROD_W-3:0], 2'b00};
        end
        return o;
    endfunction

    // signed quotient: force out of range when the quotient had too many bits
    function automatic logic [DATA_WIDTH:0] div_fmt(input logic [QBITS-1:0] q,
                                                    input logic neg, input logic big);
        logic signed [WIDE_W-1:0] w;
        w = $signed({{(WIDE_W-QBITS){1'b0}}, q});
        if (neg)
            w = -w;
        if (big)
            w = neg ? SAT_LO - 1 : SAT_HI + 1;
        return sat_wide(w);
    endfunction

    // stage 1: products
    assign x4 = (head.kind == K_MAG) ? head.a_re : head.b_re;
    assign x5 = (head.kind == K_MAG) ? head.a_im : head.b_im;

    always_ff @(posedge clk)
    begin
        k1_reg  <= head.kind;
        eq1_reg <= head.is_equal;
        ar1_reg <= head.a_re;
        ai1_reg <= head.a_im;
        br1_reg <= head.b_re;
        bi1_reg <= head.b_im;
        m0_reg  <= head.a_re * head.b_re;
        m1_reg  <= head.a_im * head.b_im;
        m2_reg  <= head.a_re * head.b_im;
        m3_reg  <= head.a_im * head.b_re;
        m4_reg  <= x4 * x4;
        m5_reg  <= x5 * x5;
    end

    // stage 2: sums
    always_comb
    begin
        case (k1_reg)
            K_ADD:
            begin
                sre2_next = WIDE_W'(ar1_reg) + WIDE_W'(br1_reg);
                sim2_next = WIDE_W'(ai1_reg) + WIDE_W'(bi1_reg);
            end
            K_SUB:
            begin
                sre2_next = WIDE_W'(ar1_reg) - WIDE_W'(br1_reg);
                sim2_next = WIDE_W'(ai1_reg) - WIDE_W'(bi1_reg);
            end
            K_MUL:
            begin
                sre2_next = WIDE_W'(m0_reg) - WIDE_W'(m1_reg);
                sim2_next = WIDE_W'(m2_reg) + WIDE_W'(m3_reg);
            end
            K_DIV:
            begin
                sre2_next = WIDE_W'(m0_reg) + WIDE_W'(m1_reg);
                sim2_next = WIDE_W'(m3_reg) - WIDE_W'(m2_reg);
            end
            default:
            begin
                sre2_next = '0;
                sim2_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        k2_reg   <= k1_reg;
        eq2_reg  <= eq1_reg;
        sre2_reg <= sre2_next;
        sim2_reg <= sim2_next;
        sq2_reg  <= $unsigned(m4_reg) + $unsigned(m5_reg);
    end

    // stage 3: magnitudes for the divider, final values for add/sub/mul
    always_comb
    begin
        case (k2_reg)
            K_ADD, K_SUB:
            begin
                fre3_next = sat_wide(sre2_reg);
                fim3_next = sat_wide(sim2_reg);
            end
            K_MUL:
            begin
                fre3_next = sat_wide(sre2_reg >>> FRAC_BITS);
                fim3_next = sat_wide(sim2_reg >>> FRAC_BITS);
            end
            default:
            begin
                fre3_next = '0;
                fim3_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        k3_reg   <= k2_reg;
        eq3_reg  <= eq2_reg;
        nre3_reg <= sre2_reg[WIDE_W-1];
        nim3_reg <= sim2_reg[WIDE_W-1];
        mre3_reg <= PROD_W'(sre2_reg[WIDE_W-1] ? -sre2_reg : sre2_reg);
        mim3_reg <= PROD_W'(sim2_reg[WIDE_W-1] ? -sim2_reg : sim2_reg);
        d3_reg   <= sq2_reg;
        fre3_reg <= fre3_next;
        fim3_reg <= fim3_next;
    end

    // load the first digit stage
    assign nfull_re = {mre3_reg, {FRAC_BITS{1'b0}}};
    assign nfull_im = {mim3_reg, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        ld.kind    = k3_reg;
        ld.eq      = eq3_reg;
        ld.dz      = (d3_reg == '0);
        ld.ovf     = fre3_reg[DATA_WIDTH] | fim3_reg[DATA_WIDTH];
        ld.neg_re  = nre3_reg;
        ld.neg_im  = nim3_reg;
        ld.fres_re = fre3_reg[DATA_WIDTH-1:0];
        ld.fres_im = fim3_reg[DATA_WIDTH-1:0];
        ld.d       = d3_reg;
        ld.rr_re   = PROD_W'(nfull_re[PROD_W+FRAC_BITS-1:QBITS]);
        ld.rr_im   = PROD_W'(nfull_im[PROD_W+FRAC_BITS-1:QBITS]);
        // quotient needs more bits than kept: saturate
        ld.big_re  = (PROD_W'(nfull_re[PROD_W+FRAC_BITS-1:QBITS]) >= d3_reg);
        ld.big_im  = (PROD_W'(nfull_im[PROD_W+FRAC_BITS-1:QBITS]) >= d3_reg);
        ld.nlo_re  = nfull_re[QBITS-1:0];
        ld.nlo_im  = nfull_im[QBITS-1:0];
        ld.q_re    = '0;
        ld.q_im    = '0;
        ld.sx      = d3_reg;
        ld.srem    = '0;
        ld.sroot   = '0;
    end

    always_comb
    begin
        pipe_next[0] = ld;
        for (int i = 0; i < STEPS; i++)
            pipe_next[i+1] = div_step(pipe_reg[i], (i < ROOT_W));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= STEPS; i++)
            pipe_reg[i] <= pipe_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i <= STEPS; i++)
                pv_reg[i] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= head_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            pv_reg[0] <= v3_reg;
            for (int i = 0; i < STEPS; i++)
                pv_reg[i+1] <= pv_reg[i];
            done_reg <= pv_reg[STEPS];
        end
    end

    // output formatting
    always_comb
    begin
        logic [DATA_WIDTH:0] fr;
        logic [DATA_WIDTH:0] fi;
        fr = div_fmt(pipe_reg[STEPS].q_re, pipe_reg[STEPS].neg_re, pipe_reg[STEPS].big_re);
        fi = div_fmt(pipe_reg[STEPS].q_im, pipe_reg[STEPS].neg_im, pipe_reg[STEPS].big_im);
        result_next = '0;
        case (pipe_reg[STEPS].kind)
            K_ADD, K_SUB, K_MUL:
            begin
                result_next.res_re   = pipe_reg[STEPS].fres_re;
                result_next.res_im   = pipe_reg[STEPS].fres_im;
                result_next.overflow = pipe_reg[STEPS].ovf;
            end
            K_DIV:
            begin
                if (pipe_reg[STEPS].dz)
                    result_next.div_zero = 1'b1;
                else
                begin
                    result_next.res_re   = fr[DATA_WIDTH-1:0];
                    result_next.res_im   = fi[DATA_WIDTH-1:0];
                    result_next.overflow = fr[DATA_WIDTH] | fi[DATA_WIDTH];
                end
            end
            K_EQ:
                result_next.is_equal = pipe_reg[STEPS].eq;
            K_MAG:
            begin
                fr = sat_wide($signed({{(WIDE_W-ROOT_W){1'b0}}, pipe_reg[STEPS].sroot}));
                result_next.res_re   = fr[DATA_WIDTH-1:0];
                result_next.overflow = fr[DATA_WIDTH];
            end
            default:
                result_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hw/rtl/complex_arithmetic_unit.sv @@
// Channel    Ports                   Handshake
// request    start, busy, request    taken on a clock edge with start high and busy low
// result     done, result            done marks one valid cycle; always taken
//
// One request per cycle sustained. Each result passes, in order, through
// the front register, the queue, three multiply/sum/setup stages, a load stage,
// 33 quotient digit stages (the square root shares their slots) and the output register.
// Reset clears all valid flags and the queue; payload registers are not reset.
// Busy rises only when the queue between front and back is nearly full.
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output res_t result
);

    q_stat_t q_stat;
    logic    push;
    item_t   push_item;
    logic    head_valid;
    item_t   head;

    cau_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .q_stat  (q_stat),
        .busy    (busy),
        .push    (push),
        .item    (push_item)
    );

    cau_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .q_stat     (q_stat),
        .head_valid (head_valid),
        .head       (head)
    );

    cau_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .done       (done),
        .result     (result)
    );

endmodule

@@ hw/rtl/cau_checker.sv @@
module cau_checker
    import cau_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input res_t result
);

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.is_equal && result.div_zero))
        else $error("equal and divide-by-zero flags both set");

    a_div_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.div_zero) |->
            (result.res_re == '0 && result.res_im == '0 && !result.overflow))
        else $error("divide by zero with nonzero result");

    a_equal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_equal) |->
            (result.res_re == '0 && result.res_im == '0 && !result.overflow))
        else $error("equality result carries data");

    a_no_result_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!start && !$past(start)) |-> !(busy && $past(!busy) && !done && $past(!done)))
        else $error("busy rose with no traffic");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import cau_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 100;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    res_t result;

    req_t pending_q[$];
    res_t expected_q[$];

    int   n_mismatch;
    int   n_sent;
    int   n_checked;
    int   op_seen[8];
    int   gap_left;
    bit   burst_mode;
    int   idle_cycles;

    complex_arithmetic_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Clamp a wide value to the 32-bit signed range, flag any clipping
    function automatic logic signed [31:0] clamp32(input logic signed [81:0] v, inout bit ov);
        if (v > 82'sd2147483647)
        begin
            ov = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -82'sd2147483648)
        begin
            ov = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Truncated (num * 2^16) / den, signed result, magnitude capped above the clamp range
    function automatic logic signed [81:0] frac_quotient(input logic signed [81:0] num,
                                                         input logic [79:0] den);
        logic [79:0]        mag;
        logic [79:0]        quo;
        logic signed [81:0] sq;
        mag = (num < 0) ? 80'(-num) : 80'(num);
        quo = (mag << 16) / den;
        if (quo > (80'd1 << 40))
            quo = 80'd1 << 40;
        sq = $signed({2'b00, quo});
        return (num < 0) ? -sq : sq;
    endfunction

    function automatic res_t predict_cplx(input req_t r);
        logic signed [81:0] ar;
        logic signed [81:0] ai;
        logic signed [81:0] br;
        logic signed [81:0] bi;
        logic signed [81:0] den;
        res_t               o;
        bit                 ov;
        ar = r.a_re;
        ai = r.a_im;
        br = r.b_re;
        bi = r.b_im;
        o  = '0;
        ov = 1'b0;
        case (r.operation)
            OP_ADD:
            begin
                o.res_re = clamp32(ar + br, ov);
                o.res_im = clamp32(ai + bi, ov);
            end
            OP_SUB:
            begin
                o.res_re = clamp32(ar - br, ov);
                o.res_im = clamp32(ai - bi, ov);
            end
            OP_MUL:
            begin
                o.res_re = clamp32((ar * br - ai * bi) >>> 16, ov);
                o.res_im = clamp32((ar * bi + ai * br) >>> 16, ov);
            end
            OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    o.div_zero = 1'b1;
                else
                begin
                    o.res_re = clamp32(frac_quotient(ar * br + ai * bi, den[79:0]), ov);
                    o.res_im = clamp32(frac_quotient(ai * br - ar * bi, den[79:0]), ov);
                end
            end
            OP_EQ:
                o.is_equal = (r.a_re == r.b_re) && (r.a_im == r.b_im);
            OP_MAG:
            begin
                den = ar * ar + ai * ai;
                o.res_re = clamp32($signed({18'd0, floor_sqrt(den[63:0])}), ov);
            end
            default:
                ov = 1'b0;
        endcase
        o.overflow = ov;
        return o;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        $display("[%0t] mismatch on result %0d, %s: expected %h got %h",
                 $time, n_checked, field, exp_v, got_v);
        n_mismatch++;
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 6) - 3;
            3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t make_request(input logic [2:0] op, input logic [31:0] a_re,
                                          input logic [31:0] a_im, input logic [31:0] b_re,
                                          input logic [31:0] b_im);
        req_t r;
        r.operation = op;
        r.a_re = a_re;
        r.a_im = a_im;
        r.b_re = b_re;
        r.b_im = b_im;
        return r;
    endfunction

    initial
    begin
        req_t r;
        int   k;
        start      = 1'b0;
        request    = '0;
        rst_n      = 1'b0;
        n_mismatch = 0;
        n_sent     = 0;
        n_checked  = 0;
        gap_left   = 0;
        burst_mode = 1'b0;
        foreach (op_seen[i])
            op_seen[i] = 0;

        // directed: extremes, every operation, zero denominator, undefined codes
        pending_q.push_back(make_request(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF));
        pending_q.push_back(make_request(OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h3, 32'h4));
        pending_q.push_back(make_request(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF));
        pending_q.push_back(make_request(OP_SUB, 32'h0005_0000, 32'h0, 32'h0002_0000, 32'h0));
        pending_q.push_back(make_request(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                                         32'hFFFF_0000));
        pending_q.push_back(make_request(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                         32'h7FFF_FFFF));
        pending_q.push_back(make_request(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0));
        pending_q.push_back(make_request(OP_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
        pending_q.push_back(make_request(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
        pending_q.push_back(make_request(OP_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0002_0000,
                                         32'h0001_0000));
        pending_q.push_back(make_request(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0));
        pending_q.push_back(make_request(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                         32'h8000_0000));
        pending_q.push_back(make_request(OP_DIV, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_q.push_back(make_request(OP_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678,
                                         32'h8000_0000));
        pending_q.push_back(make_request(OP_EQ, 32'h1234_5678, 32'h0, 32'h1234_5678, 32'h1));
        pending_q.push_back(make_request(OP_EQ, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF));
        pending_q.push_back(make_request(OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0));
        pending_q.push_back(make_request(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
        pending_q.push_back(make_request(OP_MAG, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0));
        pending_q.push_back(make_request(OP_MAG, 32'h0, 32'h0, 32'h0, 32'h0));
        pending_q.push_back(make_request(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         32'hFFFF_FFFF));
        pending_q.push_back(make_request(3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h2));

        for (k = 0; k < 1200; k++)
        begin
            r = make_request($urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7))
                                                       : 3'($urandom_range(0, 5)),
                             pick_operand(), pick_operand(), pick_operand(), pick_operand());
            if (r.operation == OP_EQ && $urandom_range(0, 1))
            begin
                r.b_re = r.a_re;
                r.b_im = r.a_im;
            end
            if (r.operation == OP_DIV && $urandom_range(0, 7) == 0)
            begin
                r.b_re = '0;
                r.b_im = '0;
            end
            pending_q.push_back(r);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && start == 1'b0);
        wait (expected_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests (add %0d, sub %0d, mul %0d, div %0d, eq %0d, mag %0d,",
                 n_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5]);
        $display("undefined %0d); checked %0d results, %0d mismatches.",
                 op_seen[6] + op_seen[7], n_checked, n_mismatch);
        if (n_mismatch == 0 && expected_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Driver: hold start with the next request or drop it for a drawn gap
    always @(posedge clk)
    begin
        bit   accepted;
        bit   hold_for_drain;
        bit   next_start;
        req_t next_req;
        accepted       = rst_n && start && !busy;
        next_start     = start;
        next_req       = request;
        if (accepted)
        begin
            expected_q.push_back(predict_cplx(request));
            op_seen[request.operation]++;
            n_sent++;
            void'(pending_q.pop_front());
            if (n_sent % 100 == 0)
                burst_mode = !burst_mode;
            gap_left   = burst_mode ? 0 : $urandom_range(0, 10);
            next_start = 1'b0;
        end
        // drain the pipe completely twice during the run
        hold_for_drain = (n_sent == 300 || n_sent == 800) && expected_q.size() != 0;
        if (rst_n && (accepted || !start))
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_q.size() != 0 && !hold_for_drain)
            begin
                next_start = 1'b1;
                next_req   = pending_q[0];
            end
        end
        start   <= next_start;
        request <= next_req;
    end

    // Monitor: every done cycle must match the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", '0, {result.res_re, result.res_im});
            end
            else
            begin
                want = expected_q.pop_front();
                if (result.res_re !== want.res_re)
                    report_mismatch("res_re", {32'd0, want.res_re}, {32'd0, result.res_re});
                if (result.res_im !== want.res_im)
                    report_mismatch("res_im", {32'd0, want.res_im}, {32'd0, result.res_im});
                if (result.is_equal !== want.is_equal)
                    report_mismatch("is_equal", {63'd0, want.is_equal},
                                    {63'd0, result.is_equal});
                if (result.div_zero !== want.div_zero)
                    report_mismatch("div_zero", {63'd0, want.div_zero},
                                    {63'd0, result.div_zero});
                if (result.overflow !== want.overflow)
                    report_mismatch("overflow", {63'd0, want.overflow},
                                    {63'd0, result.overflow});
            end
            n_checked++;
        end
    end

    // Watchdog: count cycles with no request or result taken
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] timeout: %0d results outstanding", $time, expected_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

endmodule
